// ----- rtl/addr_tbl_pkg.sv -----
// Shared types and constants for the address table with aging.
`default_nettype none

package addr_tbl_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] TTL_RESET = 32'd60000;
  localparam logic [15:0] HITS_MAX  = 16'hFFFF;

  localparam logic [1:0] CMD_SIGHT = 2'd0;
  localparam logic [1:0] CMD_SWEEP = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_SWEPT    = 3'd4,
    ST_READ_OK  = 3'd5,
    ST_READ_OOR = 3'd6
  } res_status_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [47:0]        address;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        now_ms;
    logic [6:0]         read_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         entry_index;
    logic [7:0]         entry_count;
    logic [7:0]         removed_count;
    logic [47:0]        entry_address;
    logic signed [7:0]  entry_signal;
    logic [31:0]        entry_time;
    logic [15:0]        entry_hits;
  } out_item_t;

  typedef struct packed {
    logic [47:0]        addr;
    logic signed [7:0]  sig;
    logic [31:0]        tstamp;
    logic [15:0]        hits;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic        load;
    logic        rd_scan;
    logic        ptr_inc;
    logic        rd_last;
    logic        rd_ri;
    logic        track;
    logic        wr_hit;
    logic        wr_new;
    logic        wr_move;
    logic        res_zero;
    logic        res_read;
    res_status_t res_status;
    logic        out_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       addr_zero;
    logic       ri_in_range;
    logic       scan_end;
    logic       rd_pend;
    logic       hit;
    logic       expired;
    logic       out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/addr_tbl_dp.sv -----
// Datapath: entry memory, scan pointer, counters, result and output registers.
`default_nettype none

module addr_tbl_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire addr_tbl_pkg::in_item_t   in_data,
  input  wire logic                     cfg_we,
  input  wire logic [31:0]              cfg_wdata,
  input  wire addr_tbl_pkg::dp_cmd_t    cmd,
  output addr_tbl_pkg::dp_stat_t        stat,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output addr_tbl_pkg::out_item_t       out_data
);
  import addr_tbl_pkg::*;

  entry_t mem [TABLE_DEPTH];

  in_item_t    item_r;
  logic [31:0] ttl_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  entry_t      rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic        rd_pend_r;
  logic [IDX_W-1:0] min_idx_r;
  logic [31:0] min_time_r;
  res_status_t res_status_r;
  logic [6:0]  res_idx_r;
  logic [CNT_W-1:0] res_removed_r;
  entry_t      res_entry_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             full;
  logic [IDX_W-1:0] new_idx;
  entry_t           hit_entry;
  entry_t           new_entry;
  logic [31:0]      age;

  assign full    = (count_r == CNT_W'(TABLE_DEPTH));
  assign new_idx = full ? min_idx_r : count_r[IDX_W-1:0];
  assign age     = item_r.now_ms - rd_data_r.tstamp;

  always_comb begin
    hit_entry        = rd_data_r;
    hit_entry.sig    = item_r.signal_dbm;
    hit_entry.tstamp = item_r.now_ms;
    if (rd_data_r.hits != HITS_MAX) begin
      hit_entry.hits = rd_data_r.hits + 16'd1;
    end
    new_entry.addr   = item_r.address;
    new_entry.sig    = item_r.signal_dbm;
    new_entry.tstamp = item_r.now_ms;
    new_entry.hits   = 16'd1;
  end

  // Memory port selection.
  always_comb begin
    rd_en   = cmd.rd_scan | cmd.rd_last | cmd.rd_ri;
    rd_addr = ptr_r[IDX_W-1:0];
    if (cmd.rd_last) begin
      rd_addr = IDX_W'(count_r - CNT_W'(1));
    end else if (cmd.rd_ri) begin
      rd_addr = IDX_W'(item_r.read_index);
    end
    wr_en   = cmd.wr_hit | cmd.wr_new | cmd.wr_move;
    wr_addr = ptr_r[IDX_W-1:0];
    wr_data = rd_data_r;
    if (cmd.wr_hit) begin
      wr_addr = rd_idx_r;
      wr_data = hit_entry;
    end else if (cmd.wr_new) begin
      wr_addr = new_idx;
      wr_data = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  always_comb begin
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    removed_nxt = removed_r;
    if (cmd.load) begin
      ptr_nxt     = '0;
      removed_nxt = '0;
    end
    if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    if (cmd.wr_new && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    // Hole filled from the last entry: shrink the table, keep the pointer.
    if (cmd.wr_move) begin
      count_nxt   = count_r - CNT_W'(1);
      removed_nxt = removed_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r       <= TTL_RESET;
      count_r     <= '0;
      ptr_r       <= '0;
      removed_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ttl_r <= cfg_wdata;
      end
      count_r   <= count_nxt;
      ptr_r     <= ptr_nxt;
      removed_r <= removed_nxt;
      rd_pend_r <= rd_en;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    // Oldest entry: first one with the smallest time stamp wins.
    if (cmd.track && rd_pend_r) begin
      if (rd_idx_r == '0 || rd_data_r.tstamp < min_time_r) begin
        min_idx_r  <= rd_idx_r;
        min_time_r <= rd_data_r.tstamp;
      end
    end
    if (cmd.wr_hit) begin
      res_status_r  <= ST_HIT;
      res_idx_r     <= 7'(rd_idx_r);
      res_removed_r <= '0;
      res_entry_r   <= hit_entry;
    end else if (cmd.wr_new) begin
      res_status_r  <= full ? ST_REPLACED : ST_INSERTED;
      res_idx_r     <= 7'(new_idx);
      res_removed_r <= '0;
      res_entry_r   <= new_entry;
    end else if (cmd.res_read) begin
      res_status_r  <= ST_READ_OK;
      res_idx_r     <= item_r.read_index;
      res_removed_r <= '0;
      res_entry_r   <= rd_data_r;
    end else if (cmd.res_zero) begin
      res_status_r  <= cmd.res_status;
      res_idx_r     <= (cmd.res_status == ST_READ_OOR) ? item_r.read_index : 7'd0;
      res_removed_r <= (cmd.res_status == ST_SWEPT) ? removed_r : '0;
      res_entry_r   <= '0;
    end
    if (cmd.out_load) begin
      out_r.status        <= res_status_r;
      out_r.entry_index   <= res_idx_r;
      out_r.entry_count   <= 8'(count_r);
      out_r.removed_count <= 8'(res_removed_r);
      out_r.entry_address <= res_entry_r.addr;
      out_r.entry_signal  <= res_entry_r.sig;
      out_r.entry_time    <= res_entry_r.tstamp;
      out_r.entry_hits    <= res_entry_r.hits;
    end
  end

  always_comb begin
    stat.cmd         = item_r.cmd;
    stat.addr_zero   = (item_r.address == 48'd0);
    stat.ri_in_range = (CNT_W'(item_r.read_index) < count_r);
    stat.scan_end    = (ptr_r >= count_r);
    stat.rd_pend     = rd_pend_r;
    stat.hit         = rd_pend_r && (rd_data_r.addr == item_r.address);
    stat.expired     = (age > ttl_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/addr_tbl_ctrl.sv -----
// Controller: sequences lookup, insert, sweep and read over the datapath.
`default_nettype none

module addr_tbl_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire addr_tbl_pkg::dp_stat_t stat,
  output addr_tbl_pkg::dp_cmd_t       cmd
);
  import addr_tbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_HIT,
    S_NEW,
    S_W_RD,
    S_W_CHK,
    S_W_MOVE,
    S_R_RD,
    S_R_DATA,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_IGNORED;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_SIGHT: begin
            if (stat.addr_zero) begin
              cmd.res_zero = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          CMD_SWEEP: state_nxt = S_W_RD;
          CMD_READ: begin
            if (stat.ri_in_range) begin
              state_nxt = S_R_RD;
            end else begin
              cmd.res_zero   = 1'b1;
              cmd.res_status = ST_READ_OOR;
              state_nxt      = S_FIN;
            end
          end
          default: begin
            cmd.res_zero = 1'b1;
            state_nxt    = S_FIN;
          end
        endcase
      end
      // Read one entry per cycle and check the one read the cycle before.
      S_SCAN: begin
        if (stat.hit) begin
          state_nxt = S_HIT;
        end else begin
          cmd.track = 1'b1;
          if (!stat.scan_end) begin
            cmd.rd_scan = 1'b1;
            cmd.ptr_inc = 1'b1;
          end else if (!stat.rd_pend) begin
            state_nxt = S_NEW;
          end
        end
      end
      S_HIT: begin
        cmd.wr_hit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_NEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_FIN;
      end
      S_W_RD: begin
        if (stat.scan_end) begin
          cmd.res_zero   = 1'b1;
          cmd.res_status = ST_SWEPT;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_W_CHK;
        end
      end
      S_W_CHK: begin
        if (stat.expired) begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_W_MOVE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      S_W_MOVE: begin
        cmd.wr_move = 1'b1;
        state_nxt   = S_W_RD;
      end
      S_R_RD: begin
        cmd.rd_ri = 1'b1;
        state_nxt = S_R_DATA;
      end
      S_R_DATA: begin
        cmd.res_read = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // Hold the result until the output register is free.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/address_table_with_aging.sv -----
// Top level: address table with aging, controller plus datapath.
`default_nettype none

// Channel  Handshake              Payload
// in       in_valid / in_ready    in_data  (in_item_t)
// out      out_valid / out_ready  out_data (out_item_t)
// cfg      cfg_we                 cfg_wdata (ttl_ms)
//
// A sighting scans the stored entries with one memory read per cycle and
// compares the address with the entry read the cycle before; a hit ends the
// scan. A sweep reads each entry and checks its age; an expired one is replaced
// by the last entry, which is then checked in the same slot. A read fetches one
// entry. in_ready rises in the same cycle as out_valid.
// Reset leaves the table empty; memory contents are not cleared.
// A finished result sits in the output register; the next item is taken
// meanwhile and stalls only when its own result is ready before out_ready.

module address_table_with_aging (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire addr_tbl_pkg::in_item_t   in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output addr_tbl_pkg::out_item_t       out_data,
  input  wire logic                     cfg_we,
  input  wire logic [31:0]              cfg_wdata
);
  import addr_tbl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  addr_tbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  addr_tbl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the address table with aging: random and directed items, scoreboard.
`default_nettype none

module tb;
  import addr_tbl_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 500;
  localparam int POOL_SIZE      = 176;
  localparam int SAT_SIGHTINGS  = 30;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  class table_scoreboard;
    logic [47:0]       addr_mem [TABLE_DEPTH];
    logic signed [7:0] sig_mem  [TABLE_DEPTH];
    logic [31:0]       seen_mem [TABLE_DEPTH];
    logic [15:0]       hits_mem [TABLE_DEPTH];
    int unsigned       live;
    logic [31:0]       ttl;
    out_item_t         due_q[$];
    int unsigned       errors;

    function new();
      live   = 0;
      ttl    = TTL_RESET;
      errors = 0;
    endfunction

    function out_item_t answer(res_status_t st, int unsigned idx, int unsigned removed,
                               bit with_entry);
      out_item_t r;
      r               = '0;
      r.status        = st;
      r.entry_index   = idx[6:0];
      r.entry_count   = live[7:0];
      r.removed_count = removed[7:0];
      if (with_entry) begin
        r.entry_address = addr_mem[idx];
        r.entry_signal  = sig_mem[idx];
        r.entry_time    = seen_mem[idx];
        r.entry_hits    = hits_mem[idx];
      end
      return r;
    endfunction

    // Advance the table by one accepted item and queue the answer it must produce.
    function void note_item(in_item_t it);
      int unsigned idx;
      int unsigned removed;
      int unsigned i;
      int unsigned last;
      res_status_t st;
      logic [31:0] age;
      bit found;
      idx     = 0;
      removed = 0;
      found   = 1'b0;
      case (it.cmd)
        CMD_SIGHT: begin
          if (it.address == 48'd0) begin
            due_q.push_back(answer(ST_IGNORED, 0, 0, 1'b0));
          end else begin
            for (i = 0; i < live; i++) begin
              if (!found && addr_mem[i] == it.address) begin
                found = 1'b1;
                idx   = i;
              end
            end
            if (found) begin
              sig_mem[idx]  = it.signal_dbm;
              seen_mem[idx] = it.now_ms;
              if (hits_mem[idx] != HITS_MAX) hits_mem[idx] = hits_mem[idx] + 16'd1;
              st = ST_HIT;
            end else begin
              if (live < TABLE_DEPTH) begin
                idx  = live;
                live = live + 1;
                st   = ST_INSERTED;
              end else begin
                // first entry with the smallest stamp wins
                idx = 0;
                for (i = 1; i < live; i++) begin
                  if (seen_mem[i] < seen_mem[idx]) idx = i;
                end
                st = ST_REPLACED;
              end
              addr_mem[idx] = it.address;
              sig_mem[idx]  = it.signal_dbm;
              seen_mem[idx] = it.now_ms;
              hits_mem[idx] = 16'd1;
            end
            due_q.push_back(answer(st, idx, 0, 1'b1));
          end
        end
        CMD_SWEEP: begin
          i = 0;
          while (i < live) begin
            age = it.now_ms - seen_mem[i];
            if (age > ttl) begin
              // fill the hole from the tail and look at the same slot again
              last          = live - 1;
              addr_mem[i]   = addr_mem[last];
              sig_mem[i]    = sig_mem[last];
              seen_mem[i]   = seen_mem[last];
              hits_mem[i]   = hits_mem[last];
              live          = last;
              removed       = removed + 1;
            end else begin
              i = i + 1;
            end
          end
          due_q.push_back(answer(ST_SWEPT, 0, removed, 1'b0));
        end
        CMD_READ: begin
          if (int'(it.read_index) < int'(live)) begin
            due_q.push_back(answer(ST_READ_OK, it.read_index, 0, 1'b1));
          end else begin
            due_q.push_back(answer(ST_READ_OOR, it.read_index, 0, 1'b0));
          end
        end
        default: begin
          due_q.push_back(answer(ST_IGNORED, 0, 0, 1'b0));
        end
      endcase
    endfunction

    function string show(out_item_t r);
      return $sformatf("st=%0d idx=%0d cnt=%0d rm=%0d addr=%h sig=%0d t=%h hits=%0d",
                       r.status, r.entry_index, r.entry_count, r.removed_count,
                       r.entry_address, r.entry_signal, r.entry_time, r.entry_hits);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      exp = due_q.pop_front();
      if (got.status !== exp.status || got.entry_index !== exp.entry_index ||
          got.entry_count !== exp.entry_count || got.removed_count !== exp.removed_count ||
          got.entry_address !== exp.entry_address || got.entry_signal !== exp.entry_signal ||
          got.entry_time !== exp.entry_time || got.entry_hits !== exp.entry_hits) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected %s", show(exp));
          $display("                 actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  table_scoreboard sb;
  bit              idle_on;
  int              stall_left   = 0;
  int              quiet_cycles = 0;
  logic [31:0]     wall_ms;
  logic [47:0]     addr_pool [POOL_SIZE];

  address_table_with_aging dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= int'($urandom_range(0, 7));
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] c, logic [47:0] a, logic [7:0] s,
                                         logic [31:0] t, logic [6:0] ri);
    in_item_t it;
    it.cmd        = c;
    it.address    = a;
    it.signal_dbm = s;
    it.now_ms     = t;
    it.read_index = ri;
    return it;
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [47:0] a;
    a[47:32] = 16'($urandom);
    a[31:0]  = $urandom;
    return a;
  endfunction

  // Mostly reuse known devices so hits and a full table both happen.
  function automatic logic [47:0] pick_addr();
    if ($urandom_range(0, 15) == 0) return rand_addr();
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic drive_item(input in_item_t it);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 8));
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_item(it);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [31:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.ttl = v;
  endtask

  task automatic run_traffic(input int count);
    in_item_t    it;
    int          pick;
    logic [31:0] t;
    logic [6:0]  ri;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      // hold the clock now and then so equal stamps occur
      if ($urandom_range(0, 3) != 0) wall_ms = wall_ms + $urandom_range(1, 600);
      pick = int'($urandom_range(0, 99));
      if (pick < 64) begin
        it = make_item(CMD_SIGHT, pick_addr(), 8'($urandom), wall_ms, 7'($urandom));
      end else if (pick < 74) begin
        t = wall_ms;
        if ($urandom_range(0, 3) == 0) t = t + $urandom_range(0, 200000);
        it = make_item(CMD_SWEEP, rand_addr(), 8'($urandom), t, 7'($urandom));
      end else if (pick < 90) begin
        if (sb.live != 0 && $urandom_range(0, 4) != 0) begin
          ri = 7'($urandom_range(0, sb.live - 1));
        end else begin
          ri = 7'($urandom);
        end
        it = make_item(CMD_READ, rand_addr(), 8'($urandom), $urandom, ri);
      end else if (pick < 94) begin
        it = make_item(CMD_SIGHT, 48'd0, 8'($urandom), $urandom, 7'($urandom));
      end else if (pick < 97) begin
        it = make_item(CMD_SPARE, rand_addr(), 8'($urandom), $urandom, 7'($urandom));
      end else begin
        it = make_item(CMD_SIGHT, pick_addr(), 8'($urandom), $urandom, 7'($urandom));
      end
      drive_item(it);
    end
    stop_input();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    sb        = new();
    wall_ms   = 32'hFFFF_0000;
    for (int p = 0; p < POOL_SIZE; p++) begin
      addr_pool[p] = rand_addr();
      if (addr_pool[p] == 48'd0) addr_pool[p] = 48'd1;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table, zero address, spare command, field extremes
    drive_item(make_item(CMD_READ,  48'd0, 8'h00, 32'd0, 7'd0));
    drive_item(make_item(CMD_READ,  '1, 8'hFF, '1, 7'd127));
    drive_item(make_item(CMD_SWEEP, 48'd0, 8'h00, 32'd0, 7'd0));
    drive_item(make_item(CMD_SIGHT, 48'd0, 8'h7F, '1, '1));
    drive_item(make_item(CMD_SPARE, '1, 8'hFF, '1, '1));
    drive_item(make_item(CMD_SIGHT, '1, 8'h80, 32'd0, 7'd0));
    drive_item(make_item(CMD_SIGHT, 48'd1, 8'h7F, '1, 7'd0));
    drive_item(make_item(CMD_SIGHT, '1, 8'h00, 32'd5, 7'd0));
    drive_item(make_item(CMD_SIGHT, 48'h8000_0000_0000, 8'hFF, 32'd60005, 7'd0));
    for (int r = 0; r < 4; r++) begin
      drive_item(make_item(CMD_READ, 48'd0, 8'h00, 32'd0, 7'(r)));
    end
    // age exactly at the limit stays; a wrapped age beyond it goes
    drive_item(make_item(CMD_SWEEP, 48'd0, 8'h00, 32'd60005, 7'd0));
    drive_item(make_item(CMD_SWEEP, 48'd0, 8'h00, 32'd60006, 7'd0));
    drive_item(make_item(CMD_READ,  48'd0, 8'h00, 32'd0, 7'd0));
    drive_item(make_item(CMD_READ,  48'd0, 8'h00, 32'd0, 7'd1));
    drive_item(make_item(CMD_SIGHT, 48'h8000_0000_0000, 8'h01, 32'h8000_0000, 7'd0));
    stop_input();

    write_ttl(32'hFFFF_FFFF);
    run_traffic(300);
    write_ttl(32'($urandom_range(1000, 100000)));
    run_traffic(250);
    write_ttl(32'd1);
    run_traffic(200);
    write_ttl($urandom | 32'd1);
    run_traffic(250);
    write_ttl(TTL_RESET);
    run_traffic(250);

    // Empty the table, then sight one device repeatedly without idling.
    idle_on = 1'b0;
    write_ttl(32'd1);
    wall_ms = wall_ms + 32'd10000;
    drive_item(make_item(CMD_SWEEP, 48'd0, 8'h00, wall_ms, 7'd0));
    for (int n = 0; n < SAT_SIGHTINGS; n++) begin
      drive_item(make_item(CMD_SIGHT, addr_pool[0], 8'($urandom), wall_ms, 7'($urandom)));
    end
    drive_item(make_item(CMD_READ, 48'd0, 8'h00, 32'd0, 7'd0));
    stop_input();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
